// ----- design/fepad_pkg.sv -----
// ----------------------------------------------------------------------------
// fepad_pkg
// Shared types and constants for the EOL scanline padder.
// ----------------------------------------------------------------------------
package fepad_pkg;

    localparam int WIN_W   = 24;
    localparam int LEN_W   = 7;
    localparam int MIN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int N_EOL   = 12;

    localparam logic [WIN_W-1:0] WIN_ONES = 24'hFFFFFF;
    localparam logic [LEN_W-1:0] LEN_MAX  = 7'd127;

    // Candidate EOL positions, tried in this order; lowest index wins.
    localparam logic [WIN_W-1:0] GROUP_MASK [0:2] = '{
        24'h00f00f, 24'h00ff00, 24'hf00f00
    };

    localparam logic [WIN_W-1:0] EOL_MASK [0:N_EOL-1] = '{
        24'h00f0ff, 24'h00f87f, 24'h00fc3f, 24'h00fe1f,
        24'h00ff0f, 24'h80ff07, 24'hc0ff03, 24'he0ff01,
        24'hf0ff00, 24'hf87f00, 24'hfc3f00, 24'hfe1f00
    };

    localparam logic [WIN_W-1:0] EOL_CODE [0:N_EOL-1] = '{
        24'h000080, 24'h000040, 24'h000020, 24'h000010,
        24'h000008, 24'h000004, 24'h000002, 24'h000001,
        24'h008000, 24'h004000, 24'h002000, 24'h001000
    };

    // Controller to datapath
    typedef struct packed {
        logic take;       // input item accepted this cycle
        logic emit_zero;  // load a padding zero into the output register
        logic emit_byte;  // load the line byte into the output register
        logic cnt_dec;    // one padding zero used up
    } fepad_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;  // output register empty or being taken
        logic pad_nz;     // incoming item needs padding
        logic cnt_zero;   // no padding zeros left
    } fepad_sts_t;

endpackage

// ----- design/fepad_ctrl.sv -----
// ----------------------------------------------------------------------------
// fepad_ctrl
// Sequencer: takes an item, then walks out its padding zeros and its byte.
// ----------------------------------------------------------------------------
module fepad_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  fepad_pkg::fepad_sts_t sts,
    output fepad_pkg::fepad_cmd_t cmd
);

    localparam logic ST_IN  = 1'b0;
    localparam logic ST_PAD = 1'b1;

    logic state_reg;
    logic state_next;
    logic take;
    logic pad_step;

    assign s_tready = (state_reg == ST_IN) && sts.slot_free;
    assign take     = s_tvalid && s_tready;
    assign pad_step = (state_reg == ST_PAD) && sts.slot_free;

    always_comb
    begin
        cmd.take      = take;
        cmd.emit_zero = (take && sts.pad_nz) || (pad_step && !sts.cnt_zero);
        cmd.emit_byte = (take && !sts.pad_nz) || (pad_step && sts.cnt_zero);
        cmd.cnt_dec   = pad_step && !sts.cnt_zero;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IN:
            begin
                if (take && sts.pad_nz)
                    state_next = ST_PAD;
            end
            ST_PAD:
            begin
                if (pad_step && sts.cnt_zero)
                    state_next = ST_IN;
            end
            default:
                state_next = ST_IN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IN;
        else
            state_reg <= state_next;
    end

endmodule

// ----- design/fepad_dp.sv -----
// ----------------------------------------------------------------------------
// fepad_dp
// Datapath: bit window with EOL search, line counter, pad count, output reg.
// ----------------------------------------------------------------------------
module fepad_dp
#(
    parameter int MAX_MIN_LINE = 63
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fepad_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tuser,
    input  logic                          cfg_valid,
    input  logic [fepad_pkg::MIN_W-1:0]   cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fepad_pkg::BYTE_W-1:0]  m_tdata,
    output logic                          m_tlast,
    input  fepad_pkg::fepad_cmd_t         cmd,
    output fepad_pkg::fepad_sts_t         sts
);

    logic [fepad_pkg::WIN_W-1:0]  win_reg;
    logic [fepad_pkg::WIN_W-1:0]  win_next;
    logic [fepad_pkg::LEN_W-1:0]  len_reg;
    logic [fepad_pkg::LEN_W-1:0]  len_next;
    logic [fepad_pkg::MIN_W-1:0]  min_reg;
    logic [fepad_pkg::MIN_W-1:0]  min_next;
    logic [fepad_pkg::MIN_W-1:0]  cnt_reg;
    logic [fepad_pkg::MIN_W-1:0]  cnt_next;
    logic [fepad_pkg::BYTE_W-1:0] byte_reg;
    logic                         ovalid_reg;
    logic [fepad_pkg::BYTE_W-1:0] odata_reg;
    logic                         olast_reg;

    logic [fepad_pkg::WIN_W-1:0]  win_base;
    logic [fepad_pkg::WIN_W-1:0]  win_shift;
    logic [fepad_pkg::WIN_W-1:0]  hit_mask;
    logic                         eol;
    logic [fepad_pkg::LEN_W-1:0]  len_base;
    logic [fepad_pkg::LEN_W-1:0]  len_inc;
    logic                         line_end;
    logic                         need_pad;
    logic [fepad_pkg::MIN_W-1:0]  pad;

    // Window update and EOL search
    always_comb
    begin
        win_base  = s_tuser ? fepad_pkg::WIN_ONES : win_reg;
        win_shift = {win_base[fepad_pkg::WIN_W-fepad_pkg::BYTE_W-1:0], s_tdata};
        eol       = 1'b0;
        hit_mask  = '0;
        // Scan backward so the first match in search order wins.
        for (int i = fepad_pkg::N_EOL - 1; i >= 0; i--)
        begin
            if (((win_shift & fepad_pkg::GROUP_MASK[i / 4]) == '0) &&
                ((win_shift & fepad_pkg::EOL_MASK[i]) == fepad_pkg::EOL_CODE[i]))
            begin
                eol      = 1'b1;
                hit_mask = fepad_pkg::EOL_MASK[i];
            end
        end
        win_next = win_shift | hit_mask;
    end

    // Line length and padding amount
    always_comb
    begin
        len_base = s_tuser ? '0 : len_reg;
        len_inc  = (len_base == fepad_pkg::LEN_MAX) ? fepad_pkg::LEN_MAX
                                                     : len_base + 1'b1;
        line_end = eol || s_tlast;
        need_pad = line_end && (min_reg != '0) &&
                   (len_inc < {1'b0, min_reg});
        pad      = min_reg - len_inc[fepad_pkg::MIN_W-1:0];
        len_next = line_end ? '0 : len_inc;
    end

    assign sts.slot_free = !ovalid_reg || m_tready;
    assign sts.pad_nz    = need_pad;
    assign sts.cnt_zero  = (cnt_reg == '0);

    always_comb
    begin
        min_next = cfg_data;
        if (cfg_data > fepad_pkg::MIN_W'(MAX_MIN_LINE))
            min_next = fepad_pkg::MIN_W'(MAX_MIN_LINE);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.take)
            cnt_next = pad - 1'b1;
        else if (cmd.cnt_dec)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= fepad_pkg::WIN_ONES;
            len_reg    <= '0;
            min_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                win_reg <= win_next;
                len_reg <= len_next;
            end
            if (cfg_valid)
                min_reg <= min_next;
            if (cmd.emit_zero || cmd.emit_byte)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        if (cmd.take)
            byte_reg <= s_tdata;
        if (cmd.emit_zero)
        begin
            odata_reg <= '0;
            olast_reg <= 1'b0;
        end
        else if (cmd.emit_byte)
        begin
            odata_reg <= cmd.take ? s_tdata : byte_reg;
            olast_reg <= 1'b1;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;

endmodule

// ----- design/fax_eol_min_scanline_padder_core.sv -----
// ----------------------------------------------------------------------------
// fax_eol_min_scanline_padder_core
// T.4 EOL detector that zero-fills short scanlines to a minimum length.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries coded page bytes, LSB first. s_tlast marks the last byte of
//   a strip, s_tuser marks the first byte of a page.
//   m_* carries result items; m_tlast is high on the item holding the input
//   byte itself, low on the padding zeros in front of it.
//   cfg_valid/cfg_data writes the minimum scanline length in bytes (0 turns
//   padding off). Write it only while the block is idle.
// Timing:
//   An item that needs no padding shows on m_* in the cycle after it is
//   taken. An item at a short line end makes the sequencer emit pad zeros
//   and then the byte, one output item at a time; input is held off
//   meanwhile. Sustained rate is one output item per cycle while m_tready
//   stays high, set by the single output register.
// Reset: window goes to all ones, line count and minimum to zero, output
//   register empties. A stalled receiver holds the output register and,
//   through it, the input side.
// ----------------------------------------------------------------------------
module fax_eol_min_scanline_padder_core
#(
    parameter int MAX_MIN_LINE = 63
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [fepad_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                         s_tlast,   // strip_end
    input  logic                         s_tuser,   // [0] page_start
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fepad_pkg::MIN_W-1:0]  cfg_data,  // min_scanline_bytes
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [fepad_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic                         m_tlast    // last_of_run
);

    fepad_pkg::fepad_cmd_t cmd;
    fepad_pkg::fepad_sts_t sts;

    assign cfg_ready = 1'b1;

    fepad_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fepad_dp
    #(
        .MAX_MIN_LINE (MAX_MIN_LINE)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
